>>> rtl/debounced_digit_matrix_driver_defines.svh
// Assertion macros shared by the digit matrix driver RTL.
`ifndef DEBOUNCED_DIGIT_MATRIX_DRIVER_DEFINES_SVH
`define DEBOUNCED_DIGIT_MATRIX_DRIVER_DEFINES_SVH

// Checked on every edge out of reset.
`define DDM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ddm assertion failed");

// Checked on every edge, reset included.
`define DDM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("ddm assertion failed");

`endif

>>> rtl/ddm_pkg.sv
// Types, codes and the digit font of the digit matrix driver.
`default_nettype none
package ddm_pkg;

  typedef enum logic [1:0] {
    CMD_UP     = 2'd0,
    CMD_DOWN   = 2'd1,
    CMD_REDRAW = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_RED      = 2'd1,
    REG_GREEN    = 2'd2,
    REG_BLUE     = 2'd3
  } cfg_reg_e;

  localparam logic [3:0]  LAST_DIGIT     = 4'd9;
  localparam logic [2:0]  GRID_LAST      = 3'd4;
  localparam logic [31:0] DEBOUNCE_RESET = 32'd200000;
  localparam logic [7:0]  RED_RESET      = 8'd135;
  localparam logic [7:0]  GREEN_RESET    = 8'd206;
  localparam logic [7:0]  BLUE_RESET     = 8'd249;

  // Frame request: one digit to draw.
  typedef struct packed {
    logic       valid;
    logic [3:0] digit;
  } frame_req_t;

  // One 5-bit glyph row, leftmost column in bit 4; digits above 9 are blank.
  function automatic logic [4:0] glyph_row(input logic [3:0] digit, input logic [2:0] row);
    logic [24:0] g;
    logic [4:0]  r;
    case (digit)
      4'd0:    g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
      4'd1:    g = {5'h04, 5'h0C, 5'h14, 5'h04, 5'h1F};
      4'd2:    g = {5'h1F, 5'h01, 5'h1F, 5'h10, 5'h1F};
      4'd3:    g = {5'h1F, 5'h01, 5'h1F, 5'h01, 5'h1F};
      4'd4:    g = {5'h12, 5'h12, 5'h1F, 5'h02, 5'h02};
      4'd5:    g = {5'h1F, 5'h10, 5'h1F, 5'h01, 5'h1F};
      4'd6:    g = {5'h1F, 5'h10, 5'h1F, 5'h11, 5'h1F};
      4'd7:    g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08};
      4'd8:    g = {5'h1F, 5'h11, 5'h1F, 5'h11, 5'h1F};
      4'd9:    g = {5'h1F, 5'h11, 5'h1F, 5'h01, 5'h1F};
      default: g = '0;
    endcase
    case (row)
      3'd0:    r = g[24:20];
      3'd1:    r = g[19:15];
      3'd2:    r = g[14:10];
      3'd3:    r = g[9:5];
      3'd4:    r = g[4:0];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ddm_front.sv
// Front end: debounce check, digit update and frame requests.
`default_nettype none
`include "debounced_digit_matrix_driver_defines.svh"
module ddm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [31:0]         timestamp_us_i,
  input  logic [31:0]         debounce_interval_i,
  input  logic                q_full_i,
  output ddm_pkg::frame_req_t push_o
);
  import ddm_pkg::*;

  logic [3:0]  digit_q, digit_d;
  logic [31:0] time_q, time_d;
  logic [31:0] elapsed;
  logic [3:0]  stepped;
  logic        accept, is_press, pass;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign elapsed    = timestamp_us_i - time_q;
  assign pass       = elapsed > debounce_interval_i;
  assign is_press   = (command_i == CMD_UP) || (command_i == CMD_DOWN);

  always_comb begin
    case (command_i)
      CMD_UP:   stepped = (digit_q >= LAST_DIGIT) ? 4'd0 : digit_q + 4'd1;
      CMD_DOWN: stepped = (digit_q == 4'd0) ? 4'd0 : digit_q - 4'd1;
      default:  stepped = digit_q;
    endcase
  end

  always_comb begin
    digit_d      = digit_q;
    time_d       = time_q;
    push_o.valid = 1'b0;
    push_o.digit = digit_q;
    if (accept) begin
      if (is_press && pass) begin
        digit_d      = stepped;
        time_d       = timestamp_us_i;
        push_o.valid = 1'b1;
        push_o.digit = stepped;
      end else if (command_i == CMD_REDRAW) begin
        push_o.valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
      time_q  <= '0;
    end else begin
      digit_q <= digit_d;
      time_q  <= time_d;
    end
  end

  `DDM_ASSERT_ALWAYS(a_digit_range, digit_q <= LAST_DIGIT)

endmodule
`default_nettype wire

>>> rtl/ddm_queue.sv
// Small FIFO of frame requests between front and back end.
`default_nettype none
`include "debounced_digit_matrix_driver_defines.svh"
module ddm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ddm_pkg::frame_req_t push_i,
  input  logic                pop_i,
  output logic                full_o,
  output ddm_pkg::frame_req_t head_o
);
  import ddm_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [3:0]    mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          push, pop;

  assign push         = push_i.valid;
  assign pop          = pop_i && (count_q != '0);
  assign full_o       = count_q == CW'(DEPTH);
  assign head_o.valid = count_q != '0;
  assign head_o.digit = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    if (pop)  rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    count_d = count_q + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= push_i.digit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `DDM_ASSERT(a_no_overflow, !(push && full_o && !pop))
  `DDM_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(DEPTH))

endmodule
`default_nettype wire

>>> rtl/ddm_back.sv
// Back end: walks the serpentine matrix and emits one word per pixel.
`default_nettype none
`include "debounced_digit_matrix_driver_defines.svh"
module ddm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ddm_pkg::frame_req_t head_i,
  output logic                pop_o,
  input  logic [23:0]         color_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [23:0]         pixel_word_o,
  output logic                last_pixel_o,
  output logic [3:0]          shown_digit_o
);
  import ddm_pkg::*;

  logic       active_q, active_d;
  logic [3:0] digit_q, digit_d;
  logic [2:0] row_q, row_d, col_q, col_d;
  logic       out_valid_q, out_valid_d;
  logic [23:0] word_q;
  logic       last_q;
  logic [3:0] shown_q;
  logic       adv, at_last, lit;
  logic [4:0] bits;
  logic [2:0] sel;

  assign adv     = active_q && (!out_valid_q || !out_stall_i);
  assign at_last = (row_q == GRID_LAST) && (col_q == GRID_LAST);
  assign pop_o   = head_i.valid && (!active_q || (adv && at_last));

  // Odd rows run right to left; the font cell is mirrored (24 - index).
  assign bits = glyph_row(digit_q, GRID_LAST - row_q);
  assign sel  = row_q[0] ? (GRID_LAST - col_q) : col_q;
  assign lit  = bits[sel];

  always_comb begin
    active_d = active_q;
    digit_d  = digit_q;
    row_d    = row_q;
    col_d    = col_q;
    if (pop_o) begin
      active_d = 1'b1;
      digit_d  = head_i.digit;
      row_d    = '0;
      col_d    = '0;
    end else if (adv && at_last) begin
      active_d = 1'b0;
    end else if (adv) begin
      if (col_q == GRID_LAST) begin
        col_d = '0;
        row_d = row_q + 3'd1;
      end else begin
        col_d = col_q + 3'd1;
      end
    end
    out_valid_d = adv ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      word_q  <= lit ? color_i : 24'd0;
      last_q  <= at_last;
      shown_q <= digit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      digit_q     <= '0;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      digit_q     <= digit_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_word_o  = word_q;
  assign last_pixel_o  = last_q;
  assign shown_digit_o = shown_q;

  `DDM_ASSERT(a_last_word, adv && at_last |=> out_valid_q && last_q)
  `DDM_ASSERT(a_active_digit, active_q |-> digit_q <= LAST_DIGIT)

endmodule
`default_nettype wire

>>> rtl/debounced_digit_matrix_driver.sv
// Top level of the debounced digit driver for a serpentine 5x5 LED matrix.
//
//   channel  direction  handshake             payload
//   in       input      in_valid_i/in_stall_o  command_i, timestamp_us_i
//   out      output     out_valid_o/out_stall_i pixel_word_o, last_pixel_o, shown_digit_o
//   cfg      input      cfg_we_i               cfg_index_i, cfg_wdata_i
//
// Each frame is 25 words, one per cycle from the back end pixel walker while
// out_stall_i is low; frames run back to back. The front end decides an item in
// the cycle it arrives; the first word then passes through the frame queue, the
// walker state and the output register. in_stall_o rises only while the frame
// queue is full. Reset clears digit and last accepted time to zero and loads the
// default color and debounce interval.
`default_nettype none
module debounced_digit_matrix_driver #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] timestamp_us_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] pixel_word_o,
  output logic        last_pixel_o,
  output logic [3:0]  shown_digit_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);
  import ddm_pkg::*;

  logic [31:0] debounce_q;
  logic [7:0]  red_q, green_q, blue_q;
  frame_req_t  push, head;
  logic        q_full, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
      red_q      <= RED_RESET;
      green_q    <= GREEN_RESET;
      blue_q     <= BLUE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE: debounce_q <= cfg_wdata_i;
        REG_RED:      red_q      <= cfg_wdata_i[7:0];
        REG_GREEN:    green_q    <= cfg_wdata_i[7:0];
        REG_BLUE:     blue_q     <= cfg_wdata_i[7:0];
        default:      ;
      endcase
    end
  end

  ddm_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (command_i),
    .timestamp_us_i      (timestamp_us_i),
    .debounce_interval_i (debounce_q),
    .q_full_i            (q_full),
    .push_o              (push)
  );

  ddm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  ddm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .color_i       ({red_q, green_q, blue_q}),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_word_o  (pixel_word_o),
    .last_pixel_o  (last_pixel_o),
    .shown_digit_o (shown_digit_o)
  );

endmodule
`default_nettype wire

>>> tb/digit_frame_checker.sv
// Checker for the digit matrix driver: predicts every pixel word and compares the output channel.
module digit_frame_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  command_i,
  input  logic [31:0] timestamp_us_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [23:0] pixel_word_i,
  input  logic        last_pixel_i,
  input  logic [3:0]  shown_digit_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned words_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ddm_pkg::*;

  typedef struct packed {
    logic [23:0] word;
    logic        last;
    logic [3:0]  digit;
  } pixel_t;

  pixel_t      pixel_q[$];
  logic [3:0]  digit_q;
  logic [31:0] stamp_q;
  logic [31:0] interval_q;
  logic [7:0]  red_q;
  logic [7:0]  green_q;
  logic [7:0]  blue_q;
  int unsigned fails;
  int unsigned words;

  initial begin
    fail_count_o    = 0;
    pending_o       = 0;
    words_checked_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin : predict
    logic [31:0] age;
    logic [24:0] font;
    logic        draw;
    pixel_t      px;
    pixel_t      want;
    int unsigned idx;
    if (!rst_ni) begin
      digit_q    = '0;
      stamp_q    = '0;
      interval_q = DEBOUNCE_RESET;
      red_q      = RED_RESET;
      green_q    = GREEN_RESET;
      blue_q     = BLUE_RESET;
      pixel_q.delete();
      fails      = 0;
      words      = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_DEBOUNCE: interval_q = cfg_wdata_i;
          REG_RED:      red_q      = cfg_wdata_i[7:0];
          REG_GREEN:    green_q    = cfg_wdata_i[7:0];
          REG_BLUE:     blue_q     = cfg_wdata_i[7:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        draw = 1'b0;
        age  = timestamp_us_i - stamp_q;
        case (cmd_e'(command_i))
          CMD_REDRAW: draw = 1'b1;
          CMD_UP, CMD_DOWN: begin
            // wrapping age, strictly past the interval
            if (age > interval_q) begin
              stamp_q = timestamp_us_i;
              draw    = 1'b1;
              if (command_i == CMD_UP) begin
                digit_q = (digit_q == LAST_DIGIT) ? 4'd0 : digit_q + 4'd1;
              end else if (digit_q != 4'd0) begin
                digit_q = digit_q - 4'd1;
              end
            end
          end
          default: ;
        endcase

        if (draw) begin
          // glyph rows top to bottom, leftmost column in the high bit of each row
          case (digit_q)
            4'd0:    font = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
            4'd1:    font = {5'h04, 5'h0C, 5'h14, 5'h04, 5'h1F};
            4'd2:    font = {5'h1F, 5'h01, 5'h1F, 5'h10, 5'h1F};
            4'd3:    font = {5'h1F, 5'h01, 5'h1F, 5'h01, 5'h1F};
            4'd4:    font = {5'h12, 5'h12, 5'h1F, 5'h02, 5'h02};
            4'd5:    font = {5'h1F, 5'h10, 5'h1F, 5'h01, 5'h1F};
            4'd6:    font = {5'h1F, 5'h10, 5'h1F, 5'h11, 5'h1F};
            4'd7:    font = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08};
            4'd8:    font = {5'h1F, 5'h11, 5'h1F, 5'h11, 5'h1F};
            4'd9:    font = {5'h1F, 5'h11, 5'h1F, 5'h01, 5'h1F};
            default: font = '0;
          endcase
          for (int i = 0; i < 25; i++) begin
            // serpentine: odd rows run right to left; cell 24-index sits at bit index
            idx      = (((i / 5) % 2) == 0) ? i : 5 * (i / 5) + 4 - (i % 5);
            px.word  = font[idx] ? {red_q, green_q, blue_q} : 24'd0;
            px.last  = (i == 24);
            px.digit = digit_q;
            pixel_q.push_back(px);
          end
        end
      end

      if (out_valid_i && !out_stall_i) begin
        words++;
        if (pixel_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("unexpected pixel word %06h last %0b digit %0d at word %0d",
                     pixel_word_i, last_pixel_i, shown_digit_i, words);
        end else begin
          want = pixel_q.pop_front();
          if (pixel_word_i !== want.word || last_pixel_i !== want.last ||
              shown_digit_i !== want.digit) begin
            fails++;
            if (fails <= 10)
              $display("mismatch at word %0d: word exp %06h got %06h, last exp %0b got %0b, %s",
                       words, want.word, pixel_word_i, want.last, last_pixel_i,
                       $sformatf("digit exp %0d got %0d", want.digit, shown_digit_i));
          end
        end
      end
    end
    fail_count_o    <= fails;
    pending_o       <= pixel_q.size();
    words_checked_o <= words;
  end

endmodule

>>> tb/debounced_digit_matrix_driver_tb.sv
// Testbench top: drives presses, redraws and register writes into the digit matrix driver.
module debounced_digit_matrix_driver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ddm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [1:0]  command      = CMD_REDRAW;
  logic [31:0] timestamp_us = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [23:0] pixel_word;
  logic        last_pixel;
  logic [3:0]  shown_digit;
  logic        cfg_we       = 1'b0;
  logic [1:0]  cfg_index    = REG_DEBOUNCE;
  logic [31:0] cfg_wdata    = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;
  int unsigned cycles       = 0;
  int unsigned items_sent   = 0;
  int unsigned hold_offs    = 0;

  // stimulus shaping only: tracks the press time the next debounce is measured from
  logic [31:0] anchor       = '0;
  logic [31:0] interval_now = DEBOUNCE_RESET;
  logic        quiet        = 1'b0;
  logic        rx_hold_req  = 1'b0;

  always #6 clk = ~clk;

  debounced_digit_matrix_driver dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .command_i      (command),
    .timestamp_us_i (timestamp_us),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .pixel_word_o   (pixel_word),
    .last_pixel_o   (last_pixel),
    .shown_digit_o  (shown_digit),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  digit_frame_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .command_i       (command),
    .timestamp_us_i  (timestamp_us),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .pixel_word_i    (pixel_word),
    .last_pixel_i    (last_pixel),
    .shown_digit_i   (shown_digit),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixel words still due", cycles, pending);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // pixel receiver: random stalls per word, one long hold-off on request
  initial begin : receiver
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      if (rx_hold_req) begin
        hold        = HOLD_CYCLES;
        rx_hold_req = 1'b0;
        hold_offs++;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 10);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Leaves valid high on return; anything that pauses must lower it first.
  task automatic send_word(input logic [1:0] cmd, input logic [31:0] ts);
    int unsigned gap;
    logic [31:0] age;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    timestamp_us <= ts;
    do @(posedge clk); while (in_stall);
    items_sent++;
    age = ts - anchor;
    if ((cmd == CMD_UP || cmd == CMD_DOWN) && age > interval_now)
      anchor = ts;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [31:0] deb, red, green, blue);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= REG_RED;
    cfg_wdata <= red;
    @(posedge clk);
    cfg_index <= REG_GREEN;
    cfg_wdata <= green;
    @(posedge clk);
    cfg_index <= REG_BLUE;
    cfg_wdata <= blue;
    @(posedge clk);
    cfg_we       <= 1'b0;
    interval_now = deb;
  endtask

  // Press runs lean up or down; stamps cluster around the debounce edge.
  task automatic random_items(input int unsigned count);
    int unsigned done;
    int unsigned pick;
    logic        up_run;
    logic [1:0]  cmd;
    logic [31:0] ts;
    done   = 0;
    up_run = 1'b1;
    while (done < count) begin
      if (done % 12 == 0)
        up_run = $urandom_range(0, 1);
      pick = $urandom_range(0, 99);
      if (pick < 3)
        cmd = CMD_UNUSED;
      else if (pick < 18)
        cmd = CMD_REDRAW;
      else
        cmd = (($urandom_range(0, 99) < 80) == up_run) ? CMD_UP : CMD_DOWN;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ts = anchor + interval_now - 1 + $urandom_range(0, 3);
        4, 5:       ts = anchor + $urandom_range(0, 5000);
        6, 7, 8:    ts = anchor + interval_now + 1 + $urandom_range(0, 100000);
        default:    ts = $urandom;
      endcase
      send_word(cmd, ts);
      if (cmd != CMD_UNUSED)
        done++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(CMD_REDRAW, 32'd0);
    send_word(CMD_UP, 32'd200000);                      // exactly the interval: bounce
    send_word(CMD_UP, 32'd200001);
    send_word(CMD_DOWN, anchor + interval_now);         // bounce
    send_word(CMD_DOWN, anchor + interval_now + 1);
    send_word(CMD_DOWN, anchor + interval_now + 1);     // down at zero holds
    send_word(CMD_UNUSED, 32'hFFFF_FFFF);
    send_word(CMD_UP, 32'hFFFF_FFFF);
    send_word(CMD_UP, anchor + interval_now);           // wraps through zero, still a bounce
    for (int k = 0; k < 9; k++)
      send_word(CMD_UP, anchor + interval_now + 1);     // 2..9 then wrap to 0
    send_word(CMD_REDRAW, 32'd0);
    send_word(CMD_UP, anchor - 1);                      // older stamp reads as a long gap

    random_items(60);
    wait_drained();
    quiet = 1'b1;
    random_items(25);
    quiet = 1'b0;
    rx_hold_req = 1'b1;
    repeat (20) send_word(CMD_REDRAW, $urandom);
    random_items(40);

    write_regs(32'd0, 32'd255, 32'd255, 32'd255);
    random_items(60);
    write_regs(32'hFFFF_FFFF, 32'd0, 32'd255, 32'd0);
    random_items(30);
    write_regs($urandom_range(1, 1000), $urandom, $urandom, $urandom);
    random_items(55);
    write_regs($urandom, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255));
    random_items(50);
    wait_drained();

    $display("run: %0d input words over five register settings, %0d pixel words checked",
             items_sent, words_checked);
    $display("run: %0d long receiver hold-off(s), %0d cycles", hold_offs, cycles);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
